// ===== hw/rtl/liveness_gated_watchdog_assert.svh =====
`ifndef LIVENESS_GATED_WATCHDOG_ASSERT_SVH
`define LIVENESS_GATED_WATCHDOG_ASSERT_SVH

// same-cycle implication
`define LGW_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lgw assertion failed");

// next-cycle implication
`define LGW_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lgw assertion failed");

`endif

// ===== hw/rtl/lgw_pkg.sv =====
package lgw_pkg;

   localparam int MODE_W     = 2;
   localparam int BUDGET_W   = 32;
   localparam int PERIOD_W   = 20;
   localparam int TIMEOUT_W  = 22;
   localparam int MARGIN_W   = 32;
   localparam int PROGRESS_W = 32;
   localparam int ELAPSED_W  = 33;
   localparam int ADDR_W     = 4;
   localparam int DATA_W     = 32;

   localparam logic [PERIOD_W-1:0]  PERIOD_RESET  = 20'd30000;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 22'd120000;
   localparam logic [MARGIN_W-1:0]  MARGIN_RESET  = 32'd600000;

   typedef enum logic [MODE_W-1:0] {
      MODE_TICK       = 2'd0,
      MODE_ALIVE      = 2'd1,
      MODE_IDLE_BEGIN = 2'd2,
      MODE_IDLE_END   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      REG_ENABLE      = 2'd0,
      REG_FEED_PERIOD = 2'd1,
      REG_TIMEOUT     = 2'd2,
      REG_IDLE_MARGIN = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic                 enable;
      logic                 arm;
      logic [PERIOD_W-1:0]  feed_period;
      logic [TIMEOUT_W-1:0] timeout;
      logic [MARGIN_W-1:0]  idle_margin;
   } lgw_cfg_type;

endpackage

// ===== hw/rtl/lgw_req_if.sv =====
interface lgw_req_if import lgw_pkg::*;;
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [BUDGET_W-1:0] idle_budget;

   modport source (output valid, output mode, output idle_budget, input ready);
   modport sink   (input valid, input mode, input idle_budget, output ready);
endinterface

// ===== hw/rtl/lgw_rsp_if.sv =====
interface lgw_rsp_if;
   logic valid;
   logic ready;
   logic fed;
   logic reset_request;
   logic idle_now;

   modport source (output valid, output fed, output reset_request, output idle_now,
                   input ready);
   modport sink   (input valid, input fed, input reset_request, input idle_now,
                   output ready);
endinterface

// ===== hw/rtl/lgw_csr.sv =====
module lgw_csr import lgw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output lgw_cfg_type       cfg
);

   logic                 enable_ff, enable_in;
   logic [PERIOD_W-1:0]  period_ff, period_in;
   logic [TIMEOUT_W-1:0] timeout_ff, timeout_in;
   logic [MARGIN_W-1:0]  margin_ff, margin_in;
   logic                 wr;
   reg_index_type        index;

   assign pready = 1'b1;
   assign wr     = psel & penable & pwrite;
   assign index  = reg_index_type'(paddr[3:2]);

   always_comb begin
      enable_in  = enable_ff;
      period_in  = period_ff;
      timeout_in = timeout_ff;
      margin_in  = margin_ff;
      if (wr) begin
         unique case (index)
            REG_ENABLE:      enable_in  = pwdata[0];
            REG_FEED_PERIOD: period_in  = pwdata[PERIOD_W-1:0];
            REG_TIMEOUT:     timeout_in = pwdata[TIMEOUT_W-1:0];
            REG_IDLE_MARGIN: margin_in  = pwdata[MARGIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         period_ff  <= PERIOD_RESET;
         timeout_ff <= TIMEOUT_RESET;
         margin_ff  <= MARGIN_RESET;
      end else begin
         enable_ff  <= enable_in;
         period_ff  <= period_in;
         timeout_ff <= timeout_in;
         margin_ff  <= margin_in;
      end
   end

   always_comb begin
      unique case (index)
         REG_ENABLE:      prdata = {{(DATA_W-1){1'b0}}, enable_ff};
         REG_FEED_PERIOD: prdata = {{(DATA_W-PERIOD_W){1'b0}}, period_ff};
         REG_TIMEOUT:     prdata = {{(DATA_W-TIMEOUT_W){1'b0}}, timeout_ff};
         REG_IDLE_MARGIN: prdata = margin_ff;
         default:         prdata = '0;
      endcase
   end

   // rising enable acts as an initial feed
   assign cfg.enable      = enable_ff;
   assign cfg.arm         = wr && (index == REG_ENABLE) && pwdata[0] && !enable_ff;
   assign cfg.feed_period = period_ff;
   assign cfg.timeout     = timeout_ff;
   assign cfg.idle_margin = margin_ff;

endmodule

// ===== hw/rtl/lgw_core.sv =====
module lgw_core import lgw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  lgw_cfg_type cfg,
   lgw_req_if.sink     req_chan,
   lgw_rsp_if.source   rsp_chan
);

   // input word register
   logic                  in_valid_ff, in_valid_in;
   mode_type              in_mode_ff;
   logic [BUDGET_W-1:0]   in_budget_ff;

   // watchdog state
   logic [PROGRESS_W-1:0] progress_ff, progress_in;
   logic [PROGRESS_W-1:0] last_seen_ff, last_seen_in;
   logic                  idle_ff, idle_in;
   logic [ELAPSED_W-1:0]  elapsed_ff, elapsed_in;
   logic [BUDGET_W-1:0]   budget_ff, budget_in;
   logic [PERIOD_W-1:0]   phase_ff, phase_in;
   logic [TIMEOUT_W-1:0]  since_ff, since_in;
   logic                  latched_ff, latched_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_fed_ff;
   logic                  rsp_reset_ff;
   logic                  rsp_idle_ff;

   logic                  fire;
   logic                  accept;
   logic                  fed;
   logic                  healthy;
   logic [PERIOD_W-1:0]   period;
   logic [TIMEOUT_W-1:0]  limit;
   logic [PERIOD_W:0]     phase_sum;
   logic [ELAPSED_W-1:0]  idle_limit;
   logic [TIMEOUT_W-1:0]  since_inc;

   assign fire   = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !in_valid_ff || fire;

   assign period     = (cfg.feed_period == '0) ? PERIOD_W'(1) : cfg.feed_period;
   assign limit      = (cfg.timeout == '0) ? TIMEOUT_W'(1) : cfg.timeout;
   assign phase_sum  = {1'b0, phase_ff} + (PERIOD_W+1)'(1);
   assign idle_limit = {1'b0, budget_ff} + {1'b0, cfg.idle_margin};
   assign since_inc  = (since_ff < limit) ? since_ff + TIMEOUT_W'(1) : since_ff;

   always_comb begin
      progress_in  = progress_ff;
      last_seen_in = last_seen_ff;
      idle_in      = idle_ff;
      elapsed_in   = elapsed_ff;
      budget_in    = budget_ff;
      phase_in     = phase_ff;
      since_in     = since_ff;
      latched_in   = latched_ff;
      fed          = 1'b0;
      healthy      = 1'b0;
      if (cfg.arm) begin
         since_in = '0;
         phase_in = '0;
         idle_in  = 1'b0;
      end else if (fire) begin
         unique case (in_mode_ff)
            MODE_TICK: begin
               if (cfg.enable && !latched_ff) begin
                  if (idle_ff && (elapsed_ff != '1)) begin
                     elapsed_in = elapsed_ff + ELAPSED_W'(1);
                  end
                  since_in = since_inc;
                  if (phase_sum >= {1'b0, period}) begin
                     phase_in = '0;
                     if (idle_ff) begin
                        healthy = elapsed_in < idle_limit;
                     end else begin
                        healthy      = progress_ff != last_seen_ff;
                        last_seen_in = progress_ff;
                     end
                     if (healthy) begin
                        since_in = '0;
                        fed      = 1'b1;
                     end
                  end else begin
                     phase_in = phase_sum[PERIOD_W-1:0];
                  end
                  if (since_in >= limit) begin
                     latched_in = 1'b1;
                  end
               end
            end
            MODE_ALIVE: begin
               progress_in = progress_ff + PROGRESS_W'(1);
            end
            MODE_IDLE_BEGIN: begin
               if (cfg.enable) begin
                  budget_in  = in_budget_ff;
                  elapsed_in = '0;
                  idle_in    = 1'b1;
               end
            end
            MODE_IDLE_END: begin
               if (cfg.enable) begin
                  idle_in     = 1'b0;
                  progress_in = progress_ff + PROGRESS_W'(1);
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         progress_ff  <= '0;
         last_seen_ff <= '0;
         idle_ff      <= 1'b0;
         elapsed_ff   <= '0;
         budget_ff    <= '0;
         phase_ff     <= '0;
         since_ff     <= '0;
         latched_ff   <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         progress_ff  <= progress_in;
         last_seen_ff <= last_seen_in;
         idle_ff      <= idle_in;
         elapsed_ff   <= elapsed_in;
         budget_ff    <= budget_in;
         phase_ff     <= phase_in;
         since_ff     <= since_in;
         latched_ff   <= latched_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_mode_ff   <= mode_type'(req_chan.mode);
         in_budget_ff <= req_chan.idle_budget;
      end
      if (fire) begin
         rsp_fed_ff   <= fed;
         rsp_reset_ff <= latched_in;
         rsp_idle_ff  <= idle_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.fed           = rsp_fed_ff;
   assign rsp_chan.reset_request = rsp_reset_ff;
   assign rsp_chan.idle_now      = rsp_idle_ff;

endmodule

// ===== hw/rtl/liveness_gated_watchdog.sv =====
// an accepted word waits in the input register until the result register can take it
// throughput: one word per cycle, limited only by the result side's ready
// the input register refills in the cycle its word moves to the result register
// reset: synchronous, active high; clears all watchdog state and the valid bits of both registers
// configuration returns to disabled, 30000 ms period, 120000 ms timeout, 600000 ms margin
module liveness_gated_watchdog import lgw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   lgw_req_if.sink           req_chan,
   lgw_rsp_if.source         rsp_chan,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   lgw_cfg_type cfg;

   lgw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   lgw_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== hw/rtl/lgw_checker.sv =====
`include "liveness_gated_watchdog_assert.svh"

module lgw_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_fed,
   input logic rsp_reset_request,
   input logic rsp_idle_now
);

   logic seen_ff, seen_in;

   assign seen_in = seen_ff | (rsp_valid & rsp_ready & rsp_reset_request);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   // a feed clears the countdown, so it never comes with a request
   `LGW_ASSERT_IMP(fed_excludes_request, clock, reset, rsp_valid && rsp_fed, !rsp_reset_request)
   // once delivered, the request stays
   `LGW_ASSERT_IMP(request_sticky, clock, reset, rsp_valid && seen_ff, rsp_reset_request)
   // no result straight out of reset
   `LGW_ASSERT_IMP(quiet_after_reset, clock, 1'b0, $past(reset), !rsp_valid)
   // a stalled word holds
   `LGW_ASSERT_NXT(stall_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_fed) && $stable(rsp_reset_request) && $stable(rsp_idle_now))

endmodule

bind liveness_gated_watchdog lgw_checker u_lgw_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_fed           (rsp_chan.fed),
   .rsp_reset_request (rsp_chan.reset_request),
   .rsp_idle_now      (rsp_chan.idle_now)
);
